// File: rtl/gche_pkg.sv
// Package for the grid cell hash enumerator.
// Holds the transaction structs, sequencer states, register indexes and hash constants.
// No dependencies.
package gche_pkg;

  typedef struct packed {
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic [30:0]        rect_width;
    logic [30:0]        rect_height;
  } gche_in_t;

  typedef struct packed {
    logic [31:0]        cell_hash;
    logic signed [31:0] cell_x;
    logic signed [31:0] cell_y;
    logic               last_cell;
    logic               span_clipped;
  } gche_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_HASH_X,
    ST_MIX_X,
    ST_HASH_Y,
    ST_MIX_Y,
    ST_EMIT
  } gche_state_t;

  localparam logic [1:0] REG_CELL_SIZE_LOG2   = 2'd0;
  localparam logic [1:0] REG_FNV_OFFSET_BASIS = 2'd1;
  localparam logic [1:0] REG_FNV_PRIME        = 2'd2;

  localparam logic [4:0]  CELL_SIZE_LOG2_RST   = 5'd5;
  localparam logic [31:0] FNV_OFFSET_BASIS_RST = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME_RST        = 32'd16777619;

  localparam logic [31:0] GOLDEN    = 32'h9E3779B9;
  localparam logic [7:0]  BYTE_MASK = 8'hFF;

endpackage

// File: rtl/grid_cell_hash_enumerator_core.sv
// Top level of the grid cell hash enumerator: range setup, cell walk and hash sequencer.
// Depends on gche_pkg for transaction structs, states and constants.
//
// The block takes one rectangle transaction, finds the covered grid cells on each axis
// (at most MAX_SPAN per axis) and returns one hash transaction per cell, x outer and
// y inner, the final one marked by last_cell. The input stalls for the whole rectangle.
// Range setup passes the four bounds through one shared truncating shift unit. For each
// cell the single 32x32 multiplier then runs the four FNV byte steps of each coordinate
// word, ST_MIX_X and ST_MIX_Y apply the seed mixes and ST_EMIT loads the output register.
// The next rectangle is taken while the last result still waits.
module grid_cell_hash_enumerator_core
  import gche_pkg::*;
#(
  parameter int MAX_SPAN  = 8,
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  gche_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gche_out_t   out_data
);

  localparam int SHW  = $clog2(31 + FRAC_BITS + 1);
  localparam int IDXW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;

  gche_state_t state_r, state_nxt;

  logic [4:0]  cell_size_log2_r;
  logic [31:0] fnv_offset_basis_r;
  logic [31:0] fnv_prime_r;

  gche_in_t    rect_r, rect_nxt;
  logic [1:0]  step_r, step_nxt;
  logic [32:0] lo_r, lo_nxt;
  logic [31:0] first_y_r, first_y_nxt;
  logic [IDXW-1:0] last_x_r, last_x_nxt;
  logic [IDXW-1:0] last_y_r, last_y_nxt;
  logic [IDXW-1:0] i_r, i_nxt;
  logic [IDXW-1:0] j_r, j_nxt;
  logic        clip_r, clip_nxt;
  logic [31:0] cx_r, cx_nxt;
  logic [31:0] cy_r, cy_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic        out_valid_r, out_valid_nxt;
  gche_out_t   out_data_r, out_data_nxt;

  logic        in_fire;
  logic        out_free;
  logic        cell_last;
  logic [SHW-1:0] shamt;
  logic [32:0] rng_v;
  logic [32:0] rng_mag;
  logic [32:0] rng_shift;
  logic [32:0] rng_res;
  logic [33:0] rng_diff;
  logic        rng_clip;
  logic [IDXW-1:0] rng_last;
  logic [31:0] hash_word;
  logic [7:0]  hash_byte;
  logic [31:0] mul_a;
  logic [31:0] mul_p;
  logic [31:0] mix_out;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign cell_last = (i_r == last_x_r) && (j_r == last_y_r);

  // Shared truncating shift unit for the four range bounds.
  always_comb begin
    shamt = SHW'(cell_size_log2_r) + SHW'(FRAC_BITS);
    case (step_r)
      2'd0:    rng_v = {rect_r.rect_x[31], rect_r.rect_x};
      2'd1:    rng_v = {rect_r.rect_x[31], rect_r.rect_x} + {2'b00, rect_r.rect_width};
      2'd2:    rng_v = {rect_r.rect_y[31], rect_r.rect_y};
      default: rng_v = {rect_r.rect_y[31], rect_r.rect_y} + {2'b00, rect_r.rect_height};
    endcase
    rng_mag   = rng_v[32] ? (~rng_v + 33'd1) : rng_v;
    rng_shift = rng_mag >> shamt;
    rng_res   = rng_v[32] ? (~rng_shift + 33'd1) : rng_shift;
    rng_diff  = {rng_res[32], rng_res} - {lo_r[32], lo_r};
    rng_clip  = (rng_diff >= 34'(MAX_SPAN));
    rng_last  = rng_clip ? IDXW'(MAX_SPAN - 1) : rng_diff[IDXW-1:0];
  end

  // Shared FNV multiply step and seed mix.
  always_comb begin
    hash_word = (state_r == ST_HASH_Y) ? cy_r : cx_r;
    hash_byte = hash_word[8*step_r +: 8] & BYTE_MASK;
    mul_a     = h_r ^ {24'd0, hash_byte};
    mul_p     = mul_a * fnv_prime_r;
    mix_out   = seed_r ^ (h_r + GOLDEN + (seed_r << 6) + (seed_r >> 2));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_RANGE;
      ST_RANGE:  if (step_r == 2'd3) state_nxt = ST_HASH_X;
      ST_HASH_X: if (step_r == 2'd3) state_nxt = ST_MIX_X;
      ST_MIX_X:  state_nxt = ST_HASH_Y;
      ST_HASH_Y: if (step_r == 2'd3) state_nxt = ST_MIX_Y;
      ST_MIX_Y:  state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = cell_last ? ST_IDLE : ST_HASH_X;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rect_nxt      = rect_r;
    step_nxt      = step_r;
    lo_nxt        = lo_r;
    first_y_nxt   = first_y_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    clip_nxt      = clip_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    h_nxt         = h_r;
    seed_nxt      = seed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          rect_nxt = in_data;
          step_nxt = 2'd0;
          clip_nxt = 1'b0;
        end
      end
      ST_RANGE: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: begin
            lo_nxt = rng_res;
            cx_nxt = rng_res[31:0];
          end
          2'd1: begin
            last_x_nxt = rng_last;
            clip_nxt   = clip_r | rng_clip;
          end
          2'd2: begin
            lo_nxt      = rng_res;
            first_y_nxt = rng_res[31:0];
            cy_nxt      = rng_res[31:0];
          end
          default: begin
            last_y_nxt = rng_last;
            clip_nxt   = clip_r | rng_clip;
            i_nxt      = '0;
            j_nxt      = '0;
            h_nxt      = fnv_offset_basis_r;
            seed_nxt   = fnv_offset_basis_r;
          end
        endcase
      end
      ST_HASH_X, ST_HASH_Y: begin
        h_nxt    = mul_p;
        step_nxt = step_r + 2'd1;
      end
      ST_MIX_X: begin
        seed_nxt = mix_out;
        h_nxt    = fnv_offset_basis_r;
      end
      ST_MIX_Y: begin
        seed_nxt = mix_out;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.cell_hash    = seed_r;
          out_data_nxt.cell_x       = cx_r;
          out_data_nxt.cell_y       = cy_r;
          out_data_nxt.last_cell    = cell_last;
          out_data_nxt.span_clipped = clip_r;
          h_nxt                     = fnv_offset_basis_r;
          seed_nxt                  = fnv_offset_basis_r;
          step_nxt                  = 2'd0;
          if (j_r == last_y_r) begin
            j_nxt  = '0;
            i_nxt  = i_r + IDXW'(1);
            cx_nxt = cx_r + 32'd1;
            cy_nxt = first_y_r;
          end else begin
            j_nxt  = j_r + IDXW'(1);
            cy_nxt = cy_r + 32'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      out_valid_r        <= 1'b0;
      cell_size_log2_r   <= CELL_SIZE_LOG2_RST;
      fnv_offset_basis_r <= FNV_OFFSET_BASIS_RST;
      fnv_prime_r        <= FNV_PRIME_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CELL_SIZE_LOG2:   cell_size_log2_r   <= cfg_data[4:0];
          REG_FNV_OFFSET_BASIS: fnv_offset_basis_r <= cfg_data;
          REG_FNV_PRIME:        fnv_prime_r        <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rect_r     <= rect_nxt;
    step_r     <= step_nxt;
    lo_r       <= lo_nxt;
    first_y_r  <= first_y_nxt;
    last_x_r   <= last_x_nxt;
    last_y_r   <= last_y_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    clip_r     <= clip_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    h_r        <= h_nxt;
    seed_r     <= seed_nxt;
    out_data_r <= out_data_nxt;
  end

  a_accept_starts_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_RANGE)
    else $error("accepted rectangle did not start range setup");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && cell_last) |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after the last cell");

  a_last_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> out_valid_r && (out_data_r.last_cell == (state_r == ST_IDLE)))
    else $error("last_cell flag disagrees with the cell walk");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HASH_X || state_r == ST_HASH_Y || state_r == ST_EMIT)
      |-> (i_r <= last_x_r) && (j_r <= last_y_r))
    else $error("cell walk index beyond the clipped span");

endmodule
